FILE: design/sdpt_pkg.sv
// Package for the shake detector: widths, register indexes, reset values and shared types.
package sdpt_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int AGE_W     = 7;
    localparam int LIMIT_W   = 6;
    localparam int THRESH_W  = 16;
    localparam int TALLY_W   = 8;
    localparam int MAX_AXES  = 3;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_MIN    = 2'd2;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  AGE_LIMIT_RST = 6'd25;
    localparam logic [THRESH_W-1:0] THRESH_RST    = 16'd25000;
    localparam logic [TALLY_W-1:0]  SHAKE_MIN_RST = 8'd3;

    // Age code of a peak that holds nothing yet
    localparam logic [AGE_W-1:0] AGE_EMPTY = 7'h7F;
    // Highest age a live peak can hold
    localparam logic [AGE_W-1:0] AGE_LIVE_MAX = 7'd64;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 8'hFF;

    // Per-axis status handed to the tally logic
    typedef struct packed {
        logic expired;  // a peak expired this sample; clears the tally
        logic over;     // spread after update is above the threshold
    } axis_status_t;

endpackage

FILE: design/sdpt_axis.sv
// One axis of the shake detector: high and low peak update and spread compare.
module sdpt_axis
(
    input  logic signed [sdpt_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_high,
    input  logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_low,
    input  logic        [sdpt_pkg::AGE_W-1:0]    high_age,
    input  logic        [sdpt_pkg::AGE_W-1:0]    low_age,
    input  logic        [sdpt_pkg::LIMIT_W-1:0]  age_limit,
    input  logic        [sdpt_pkg::THRESH_W-1:0] spread_threshold,
    output logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_high_next,
    output logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_low_next,
    output logic        [sdpt_pkg::AGE_W-1:0]    high_age_next,
    output logic        [sdpt_pkg::AGE_W-1:0]    low_age_next,
    output sdpt_pkg::axis_status_t               status
);

    logic [sdpt_pkg::AGE_W-1:0] limit_ext;
    logic high_empty;
    logic low_empty;
    logic high_expired;
    logic low_expired;
    logic high_take;
    logic low_take;
    logic signed [sdpt_pkg::SAMPLE_W:0] spread;

    assign limit_ext = {1'b0, age_limit};

    // Peak expiry and replacement
    assign high_empty   = (high_age == sdpt_pkg::AGE_EMPTY);
    assign low_empty    = (low_age == sdpt_pkg::AGE_EMPTY);
    assign high_expired = !high_empty && (high_age > limit_ext);
    assign low_expired  = !low_empty && (low_age > limit_ext);
    assign high_take    = (peak_high < sample) || high_empty || high_expired;
    assign low_take     = (sample < peak_low) || low_empty || low_expired;

    assign peak_high_next = high_take ? sample : peak_high;
    assign peak_low_next  = low_take ? sample : peak_low;
    assign high_age_next  = high_take ? '0 : high_age + 7'd1;
    assign low_age_next   = low_take ? '0 : low_age + 7'd1;

    // Spread is 17 bits wide so it never wraps
    assign spread = {peak_high_next[sdpt_pkg::SAMPLE_W-1], peak_high_next}
                  - {peak_low_next[sdpt_pkg::SAMPLE_W-1], peak_low_next};

    assign status.expired = high_expired || low_expired;
    assign status.over    = !spread[sdpt_pkg::SAMPLE_W]
                          && (spread[sdpt_pkg::SAMPLE_W-1:0] > spread_threshold);

endmodule

FILE: design/shake_detector_peak_tracker.sv
// Top level of the shake detector with per-axis windowed peak tracking.
//
// Input stream: one transaction per accelerometer sample, tdata holds
// accel_x, accel_y, accel_z (16-bit two's complement each, x lowest).
// Output stream: one transaction per sample, tdata holds shake_detected
// (bit 0) and the shake tally after the sample (bits 8:1).
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (0 age limit, 1 spread threshold, 2 shake count minimum); write only
// while no sample is in flight.
// The sample is captured in an input register, then all axis updates and
// the tally chain run combinationally into the result register. Throughput
// is one sample per cycle while the receiver accepts results, set by that
// single compute stage.
// Reset clears the peaks, marks every peak empty, zeroes the tally and
// loads the register defaults. When the receiver stalls the result is
// held; the input register still takes one more sample, then s_axis_tready
// drops until the result moves.
module shake_detector_peak_tracker
#(
    parameter int AXES = 3
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Input samples
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic [sdpt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: shake_detected[0], shake_tally[8:1], zero [15:9]
    output logic [sdpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // Configuration writes
    input  logic                               cfg_we,
    input  logic [sdpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdpt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers
    logic [sdpt_pkg::LIMIT_W-1:0]  age_limit_reg;
    logic [sdpt_pkg::THRESH_W-1:0] spread_threshold_reg;
    logic [sdpt_pkg::TALLY_W-1:0]  shake_count_min_reg;

    // Pipeline registers
    logic                           in_valid_reg;
    logic [sdpt_pkg::IN_DATA_W-1:0] in_data_reg;
    logic                           out_valid_reg;
    logic                           out_detected_reg;
    logic [sdpt_pkg::TALLY_W-1:0]   out_tally_reg;
    logic                           advance;

    // Tracker state
    logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_high_reg [AXES];
    logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_low_reg  [AXES];
    logic        [sdpt_pkg::AGE_W-1:0]    high_age_reg  [AXES];
    logic        [sdpt_pkg::AGE_W-1:0]    low_age_reg   [AXES];
    logic        [sdpt_pkg::TALLY_W-1:0]  tally_reg;

    logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_high_next [AXES];
    logic signed [sdpt_pkg::SAMPLE_W-1:0] peak_low_next  [AXES];
    logic        [sdpt_pkg::AGE_W-1:0]    high_age_next  [AXES];
    logic        [sdpt_pkg::AGE_W-1:0]    low_age_next   [AXES];
    sdpt_pkg::axis_status_t               status [AXES];
    logic        [sdpt_pkg::TALLY_W-1:0]  tally_next;
    logic                                 fired_next;

    // Handshake: compute stage moves when the result register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_tally_reg, out_detected_reg};

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg        <= sdpt_pkg::AGE_LIMIT_RST;
            spread_threshold_reg <= sdpt_pkg::THRESH_RST;
            shake_count_min_reg  <= sdpt_pkg::SHAKE_MIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdpt_pkg::REG_AGE_LIMIT:
                    age_limit_reg <= cfg_data[sdpt_pkg::LIMIT_W-1:0];
                sdpt_pkg::REG_SPREAD_THRESH:
                    spread_threshold_reg <= cfg_data;
                sdpt_pkg::REG_SHAKE_MIN:
                    shake_count_min_reg <= cfg_data[sdpt_pkg::TALLY_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // Per-axis peak units
    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        sdpt_axis u_axis
        (
            .sample           (in_data_reg[a*sdpt_pkg::SAMPLE_W +: sdpt_pkg::SAMPLE_W]),
            .peak_high        (peak_high_reg[a]),
            .peak_low         (peak_low_reg[a]),
            .high_age         (high_age_reg[a]),
            .low_age          (low_age_reg[a]),
            .age_limit        (age_limit_reg),
            .spread_threshold (spread_threshold_reg),
            .peak_high_next   (peak_high_next[a]),
            .peak_low_next    (peak_low_next[a]),
            .high_age_next    (high_age_next[a]),
            .low_age_next     (low_age_next[a]),
            .status           (status[a])
        );
    end

    // Tally chain through the axes in order x, y, z
    always_comb
    begin
        tally_next = tally_reg;
        fired_next = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            if (status[a].expired)
            begin
                tally_next = '0;
            end
            if (status[a].over && (tally_next != sdpt_pkg::TALLY_MAX))
            begin
                tally_next = tally_next + 8'd1;
            end
            if (tally_next >= shake_count_min_reg)
            begin
                fired_next = 1'b1;
                tally_next = '0;
            end
        end
    end

    // Tracker state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                peak_high_reg[a] <= '0;
                peak_low_reg[a]  <= '0;
                high_age_reg[a]  <= sdpt_pkg::AGE_EMPTY;
                low_age_reg[a]   <= sdpt_pkg::AGE_EMPTY;
            end
        end
        else if (advance)
        begin
            tally_reg <= tally_next;
            for (int a = 0; a < AXES; a++)
            begin
                peak_high_reg[a] <= peak_high_next[a];
                peak_low_reg[a]  <= peak_low_next[a];
                high_age_reg[a]  <= high_age_next[a];
                low_age_reg[a]   <= low_age_next[a];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_detected_reg <= fired_next;
            out_tally_reg    <= tally_next;
        end
    end

`ifndef ASSERT_OFF
    // A stalled result stays valid and unchanged
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped or changed while stalled");

    // A full input stage behind a stalled result must block new samples
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    // The tally register follows the result just produced
    a_tally_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_tally_reg == tally_reg))
        else $error("result tally differs from stored tally");

    // A live peak never ages past one beyond the largest limit
    for (genvar a = 0; a < AXES; a++)
    begin : g_age_chk
        a_age_range: assert property (@(posedge clk) disable iff (!rst_n)
            ((high_age_reg[a] <= sdpt_pkg::AGE_LIVE_MAX)
                || (high_age_reg[a] == sdpt_pkg::AGE_EMPTY))
            && ((low_age_reg[a] <= sdpt_pkg::AGE_LIVE_MAX)
                || (low_age_reg[a] == sdpt_pkg::AGE_EMPTY)))
            else $error("peak age out of range");
    end
`endif

endmodule

FILE: test/shake_detector_peak_tracker_tb.sv
// Testbench for the shake detector: predicts tally and shake flag, checks the result stream.
module shake_detector_peak_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    // Index past the last register: writes to it must change nothing
    localparam logic [sdpt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Ways of shaping the samples of one random item
    typedef enum int {STYLE_SWING, STYLE_QUIET, STYLE_NOISE, STYLE_RAMP} wave_style_t;

    typedef struct packed {
        bit                           detected;
        bit [sdpt_pkg::TALLY_W-1:0]   tally;
    } shake_result_t;

    // Peak and tally tracker; holds the results still owed by the block
    class shake_scoreboard;
        bit [sdpt_pkg::LIMIT_W-1:0]         age_limit;
        bit [sdpt_pkg::THRESH_W-1:0]        spread_thresh;
        bit [sdpt_pkg::TALLY_W-1:0]         shake_min;
        bit signed [sdpt_pkg::SAMPLE_W-1:0] hi_peak [sdpt_pkg::MAX_AXES];
        bit signed [sdpt_pkg::SAMPLE_W-1:0] lo_peak [sdpt_pkg::MAX_AXES];
        bit [sdpt_pkg::AGE_W-1:0]           hi_age [sdpt_pkg::MAX_AXES];
        bit [sdpt_pkg::AGE_W-1:0]           lo_age [sdpt_pkg::MAX_AXES];
        bit [sdpt_pkg::TALLY_W-1:0]         tally;
        shake_result_t                      pending [$];
        int                                 errors;

        function new();
            age_limit     = sdpt_pkg::AGE_LIMIT_RST;
            spread_thresh = sdpt_pkg::THRESH_RST;
            shake_min     = sdpt_pkg::SHAKE_MIN_RST;
            for (int ax = 0; ax < sdpt_pkg::MAX_AXES; ax++)
            begin
                hi_peak[ax] = '0;
                lo_peak[ax] = '0;
                hi_age[ax]  = sdpt_pkg::AGE_EMPTY;
                lo_age[ax]  = sdpt_pkg::AGE_EMPTY;
            end
            tally  = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [sdpt_pkg::CFG_IDX_W-1:0] idx,
                              logic [sdpt_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                sdpt_pkg::REG_AGE_LIMIT:     age_limit     = val[sdpt_pkg::LIMIT_W-1:0];
                sdpt_pkg::REG_SPREAD_THRESH: spread_thresh = val[sdpt_pkg::THRESH_W-1:0];
                sdpt_pkg::REG_SHAKE_MIN:     shake_min     = val[sdpt_pkg::TALLY_W-1:0];
                default: ;
            endcase
        endfunction

        // Replace or age one peak; an expired peak clears the tally
        function void track_peak(int ax, bit upper, bit signed [sdpt_pkg::SAMPLE_W-1:0] s);
            bit signed [sdpt_pkg::SAMPLE_W-1:0] peak;
            bit [sdpt_pkg::AGE_W-1:0]           age;
            bit                                 beats;
            bit                                 empty;
            bit                                 expired;
            peak    = upper ? hi_peak[ax] : lo_peak[ax];
            age     = upper ? hi_age[ax] : lo_age[ax];
            beats   = upper ? (s > peak) : (s < peak);
            empty   = (age == sdpt_pkg::AGE_EMPTY);
            expired = !empty && (age > {1'b0, age_limit});
            if (beats || empty || expired)
            begin
                if (expired)
                    tally = '0;
                peak = s;
                age  = '0;
            end
            else
                age = age + 1'b1;
            if (upper)
            begin
                hi_peak[ax] = peak;
                hi_age[ax]  = age;
            end
            else
            begin
                lo_peak[ax] = peak;
                lo_age[ax]  = age;
            end
        endfunction

        // Accepted sample: update every axis in order, queue the result
        function void note_sample(logic [sdpt_pkg::IN_DATA_W-1:0] d);
            shake_result_t                      r;
            int                                 spread;
            bit signed [sdpt_pkg::SAMPLE_W-1:0] s;
            r.detected = 1'b0;
            for (int ax = 0; ax < sdpt_pkg::MAX_AXES; ax++)
            begin
                s = d[ax*sdpt_pkg::SAMPLE_W +: sdpt_pkg::SAMPLE_W];
                track_peak(ax, 1'b1, s);
                track_peak(ax, 1'b0, s);
                // 17-bit spread, no wrap
                spread = int'(hi_peak[ax]) - int'(lo_peak[ax]);
                if (spread > int'(spread_thresh) && tally != sdpt_pkg::TALLY_MAX)
                    tally++;
                if (tally >= shake_min)
                begin
                    r.detected = 1'b1;
                    tally      = '0;
                end
            end
            r.tally = tally;
            pending.push_back(r);
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_result(logic [sdpt_pkg::OUT_DATA_W-1:0] d);
            shake_result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no sample pending: tdata %h", d);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (d[0] !== want.detected)
            begin
                $error("shake_detected: expected %0d, actual %0d", want.detected, d[0]);
                errors++;
            end
            if (d[sdpt_pkg::TALLY_W:1] !== want.tally)
            begin
                $error("shake_tally: expected %0d, actual %0d", want.tally,
                       d[sdpt_pkg::TALLY_W:1]);
                errors++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic [sdpt_pkg::IN_DATA_W-1:0]    s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // tdata: shake_detected[0], shake_tally[8:1], zero [15:9]
    logic [sdpt_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              cfg_we;
    logic [sdpt_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [sdpt_pkg::CFG_DATA_W-1:0]   cfg_data;

    shake_scoreboard sb;
    int              src_idle_pct  = 0;
    int              snk_stall_pct = 0;
    bit              hold_req      = 1'b0;
    int              quiet_cycles  = 0;

    shake_detector_peak_tracker dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transaction monitor on both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL shake_detector_peak_tracker");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Offer one sample, with random gaps ahead of it; returns on acceptance
    task automatic send_sample(input logic [sdpt_pkg::SAMPLE_W-1:0] x,
                               input logic [sdpt_pkg::SAMPLE_W-1:0] y,
                               input logic [sdpt_pkg::SAMPLE_W-1:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the block must be idle
    task automatic write_reg(input logic [sdpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdpt_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [sdpt_pkg::SAMPLE_W-1:0] pick_axis(wave_style_t style, int k);
        case (style)
            STYLE_SWING:
                return k[0] ? 16'($urandom_range(32767, 4000))
                            : -16'($urandom_range(32768, 4000));
            STYLE_QUIET:
                return 16'(int'($urandom_range(600)) - 300);
            STYLE_RAMP:
                return k[0] ? 16'(k) : 16'(-k);
            default:
                return 16'($urandom);
        endcase
    endfunction

    // Random phase: program the registers, then stream samples
    task automatic run_phase(input int age, input int thr, input int min_cnt, input int idle_pct,
                             input int stall_pct, input int n, input bit ramp, input bit squeeze);
        wave_style_t style;
        int          roll;
        drain();
        write_reg(sdpt_pkg::REG_AGE_LIMIT, 16'(age));
        write_reg(sdpt_pkg::REG_SPREAD_THRESH, 16'(thr));
        write_reg(sdpt_pkg::REG_SHAKE_MIN, 16'(min_cnt));
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int i = 1; i <= n; i++)
        begin
            // mostly swinging shakes, some quiet stretches and raw noise
            roll = $urandom_range(99);
            if (ramp)
                style = STYLE_RAMP;
            else if (roll < 60)
                style = STYLE_SWING;
            else if (roll < 85)
                style = STYLE_QUIET;
            else
                style = STYLE_NOISE;
            if (squeeze && i == 40)
                hold_req = 1'b1;
            send_sample(pick_axis(style, i), pick_axis(style, i + 1), pick_axis(style, i));
        end
    endtask

    // Main sequence
    initial
    begin
        sb = new();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= sdpt_pkg::REG_AGE_LIMIT;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: empty peaks, extremes, full 17-bit spread
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h8000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'h5555, 16'hAAAA, 16'h7FFF);
        send_sample(16'hAAAA, 16'h5555, 16'h8000);
        send_sample(16'h0001, 16'hFFFF, 16'h0001);

        // Zero age limit: peaks expire after one held sample
        drain();
        write_reg(sdpt_pkg::REG_AGE_LIMIT, 16'd0);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'd100, -16'd100, 16'h0000);

        // Zero minimum with the widest threshold: every axis fires
        drain();
        write_reg(sdpt_pkg::REG_SHAKE_MIN, 16'd0);
        write_reg(sdpt_pkg::REG_SPREAD_THRESH, 16'hFFFF);
        send_sample(16'd5, 16'd5, 16'd5);
        send_sample(-16'd5, 16'd6, 16'd7);

        // Write to an unused index changes nothing
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(16'd1, 16'd2, 16'd3);

        // Minimum of one, zero threshold, longest age
        drain();
        write_reg(sdpt_pkg::REG_SHAKE_MIN, 16'd1);
        write_reg(sdpt_pkg::REG_SPREAD_THRESH, 16'd0);
        write_reg(sdpt_pkg::REG_AGE_LIMIT, 16'd63);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);

        // Short age limit: every peak of each axis expires during the run of equal samples
        drain();
        write_reg(sdpt_pkg::REG_AGE_LIMIT, 16'd1);
        write_reg(sdpt_pkg::REG_SHAKE_MIN, 16'd255);
        repeat (4) send_sample(16'd7, 16'd7, 16'd7);

        // Random phases across settings and idling patterns
        run_phase(25, 25000, 3, 0, 0, 200, 1'b0, 1'b0);
        run_phase(0, 0, 1, 66, 0, 150, 1'b0, 1'b0);
        run_phase(63, 65535, 255, 0, 66, 150, 1'b0, 1'b0);
        run_phase(10, 12000, 5, 38, 38, 250, 1'b0, 1'b0);
        // Growing swings keep every peak fresh so the tally climbs to its top
        run_phase(63, 0, 255, 0, 0, 200, 1'b1, 1'b0);
        // Long receiver hold-off while samples keep coming
        run_phase(20, 20000, 2, 0, 0, 200, 1'b0, 1'b1);
        run_phase($urandom_range(63), $urandom_range(65535), $urandom_range(255, 1),
                  38, 38, 150, 1'b0, 1'b0);

        drain();
        if (sb.errors == 0)
            $display("PASS shake_detector_peak_tracker");
        else
            $display("FAIL shake_detector_peak_tracker");
        $finish;
    end

endmodule
